/* rtl/rce_pkg.sv */
// ============================================================================
// rce_pkg: shared types and constants of the Roberts cross edge stream
// Widths, the grey conversion coefficients, the line width clamp and the
// pixel position record that is passed between the position counter and the
// top level.
// ============================================================================
package rce_pkg;

  // Line buffer depth: the widest image row the block supports.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int ROW_W = 10;
  localparam int POS_W = 10;
  localparam int MAG_W = 9;

  localparam int LW_RESET = 640;

  // floor(x / 1000) equals (x * RECIP) >> RECIP_SHIFT for every x below
  // 2^28 / 544, which covers the largest product 255 * 587.
  localparam int RECIP_SHIFT = 28;
  localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + 999) / 1000;
  localparam int COEF_W      = 28;

  localparam logic [COEF_W-1:0] COEF_RED   = COEF_W'(299 * RECIP);
  localparam logic [COEF_W-1:0] COEF_GREEN = COEF_W'(587 * RECIP);
  localparam logic [COEF_W-1:0] COEF_BLUE  = COEF_W'(114 * RECIP);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             produce;
  } pos_t;

  // Effective row width: the register value held to 2 .. MAX_WIDTH.
  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] lw);
    logic [WID_W-1:0] w;
    if (lw < CFG_W'(2)) begin
      w = WID_W'(2);
    end else if (int'(lw) > MAX_WIDTH) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = WID_W'(lw);
    end
    return w;
  endfunction

endpackage

/* rtl/rce_if.sv */
// ============================================================================
// rce_if: stream channels of the Roberts cross edge stream
// Valid/ready channels for pixels in, edge results out and the line width
// configuration write.
// ============================================================================
interface rce_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rce_pkg::PIX_W-1:0]   red;
  logic [rce_pkg::PIX_W-1:0]   green;
  logic [rce_pkg::PIX_W-1:0]   blue;
  logic                        frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface rce_edge_if;
  logic                        valid;
  logic                        ready;
  logic [rce_pkg::MAG_W-1:0]   edge_magnitude;
  logic [rce_pkg::PIX_W-1:0]   edge_byte;
  logic [rce_pkg::POS_W-1:0]   out_row;
  logic [rce_pkg::POS_W-1:0]   out_col;

  modport source (output valid, edge_magnitude, edge_byte, out_row, out_col,
                  input ready);
  modport sink   (input valid, edge_magnitude, edge_byte, out_row, out_col,
                  output ready);
endinterface

interface rce_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rce_pkg::CFG_W-1:0]   line_width;

  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

/* rtl/rce_ram.sv */
// ============================================================================
// rce_ram: generic single-clock RAM
// One write port and one read port, read data registered on read enable.
// ============================================================================
module rce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rce_grey.sv */
// ============================================================================
// rce_grey: colour to grey partial terms
// Each channel is scaled by its weight and divided by 1000 through a
// reciprocal multiply; the three floored terms are summed downstream.
// ============================================================================
module rce_grey (
  input  logic [rce_pkg::PIX_W-1:0] red,
  input  logic [rce_pkg::PIX_W-1:0] green,
  input  logic [rce_pkg::PIX_W-1:0] blue,
  output logic [rce_pkg::PIX_W-1:0] part_red,
  output logic [rce_pkg::PIX_W-1:0] part_green,
  output logic [rce_pkg::PIX_W-1:0] part_blue
);
  import rce_pkg::*;

  localparam int PROD_W = PIX_W + COEF_W;

  logic [PROD_W-1:0] prod_red;
  logic [PROD_W-1:0] prod_green;
  logic [PROD_W-1:0] prod_blue;

  assign prod_red   = PROD_W'(red)   * PROD_W'(COEF_RED);
  assign prod_green = PROD_W'(green) * PROD_W'(COEF_GREEN);
  assign prod_blue  = PROD_W'(blue)  * PROD_W'(COEF_BLUE);

  // Every floored term is below 256, so the upper product bits are zero.
  assign part_red   = prod_red[RECIP_SHIFT +: PIX_W];
  assign part_green = prod_green[RECIP_SHIFT +: PIX_W];
  assign part_blue  = prod_blue[RECIP_SHIFT +: PIX_W];

endmodule

/* rtl/rce_pos.sv */
// ============================================================================
// rce_pos: raster position counter
// Tracks row and column of the incoming pixel, honoring the frame start flag
// and the effective row width, and flags positions that yield a result.
// ============================================================================
module rce_pos (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      frame_start,
  input  logic [rce_pkg::WID_W-1:0] width,
  output rce_pkg::pos_t             pos
);
  import rce_pkg::*;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_base;
  logic [COL_W-1:0] col_base;
  logic [COL_W-1:0] col_use;
  logic [WID_W-1:0] col_inc;

  always_comb begin
    row_base = frame_start ? '0 : row_r;
    col_base = frame_start ? '0 : col_r;
    // A narrower width written mid-line ends the row at once.
    col_use  = ({1'b0, col_base} >= width) ? '0 : col_base;
    col_inc  = {1'b0, col_use} + WID_W'(1);
    if (col_inc >= width) begin
      col_nxt = '0;
      row_nxt = row_base + ROW_W'(1);
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_base;
    end
    pos.row     = row_base;
    pos.col     = col_use;
    pos.produce = (row_base >= ROW_W'(2)) && (col_use >= COL_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

/* rtl/roberts_cross_edge_stream.sv */
// ============================================================================
// roberts_cross_edge_stream: Roberts cross edge detector on an RGB stream
// Grey conversion, one-row line buffer and magnitude output per pixel.
// ============================================================================
// The block takes one RGB pixel per clock in raster order and, once row and
// column are both 2 or more, returns the Roberts cross magnitude of the
// position one row and one column back, with its low byte and its position.
// A pixel transaction is taken every cycle unless the result register is full
// and not being drained; its result passes through the second-stage register
// and then the output register. The line buffer is a RAM with one write and
// one registered read port: each pixel reads its column at acceptance and
// writes it back as it retires from the second stage, with a bypass when the
// next pixel reads the column just being written. The line buffer is not
// cleared at reset; growing line_width in the middle of a frame can expose
// unwritten entries, whose results are then undefined. line_width is clamped to
// 2 .. MAX_WIDTH and should be written only while the block is idle.
// ============================================================================
module roberts_cross_edge_stream (
  input  logic        clk,
  input  logic        rst_n,
  rce_pix_if.sink     in_ch,
  rce_edge_if.source  out_ch,
  rce_cfg_if.sink     cfg_ch
);
  import rce_pkg::*;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Configuration: the clamped width is kept so the counters see it directly.
  logic [WID_W-1:0] width_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= clamp_width(CFG_W'(LW_RESET));
    end else if (cfg_ch.valid) begin
      width_r <= clamp_width(cfg_ch.line_width);
    end
  end

  // The whole pipeline moves together; it stalls only when a result waits.
  logic advance;
  logic accept;
  logic out_valid_r;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  // Position of the incoming pixel.
  pos_t pos;

  rce_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_ch.frame_start),
    .width       (width_r),
    .pos         (pos)
  );

  // Grey terms of the incoming pixel.
  logic [PIX_W-1:0] part_red, part_green, part_blue;

  rce_grey u_grey (
    .red        (in_ch.red),
    .green      (in_ch.green),
    .blue       (in_ch.blue),
    .part_red   (part_red),
    .part_green (part_green),
    .part_blue  (part_blue)
  );

  // Second stage: pixel whose line buffer read is in flight.
  logic             s1_valid_r;
  pos_t             s1_pos_r;
  logic [PIX_W-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic             fwd_hit_r;
  logic [PIX_W-1:0] fwd_data_r;
  logic [PIX_W-1:0] left_r, upper_left_r;

  logic [PIX_W-1:0] cur_grey;
  logic [PIX_W-1:0] above_ram;
  logic [PIX_W-1:0] above;
  logic [MAG_W-1:0] mag;
  logic             s1_retire;
  logic             fwd_hit_nxt;

  // The three floored terms add up to at most 254.
  assign cur_grey  = s1_red_r + s1_green_r + s1_blue_r;
  assign above     = fwd_hit_r ? fwd_data_r : above_ram;
  assign mag       = MAG_W'(abs_diff(upper_left_r, cur_grey))
                   + MAG_W'(abs_diff(left_r, above));
  assign s1_retire = s1_valid_r && advance;

  // A read of the column being written at the same edge sees the old RAM
  // word, so the new grey value is carried over in a bypass register.
  assign fwd_hit_nxt = s1_retire && (s1_pos_r.col == pos.col);

  rce_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_retire),
    .waddr (s1_pos_r.col),
    .wdata (cur_grey),
    .re    (accept),
    .raddr (pos.col),
    .rdata (above_ram)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r   <= pos;
      s1_red_r   <= part_red;
      s1_green_r <= part_green;
      s1_blue_r  <= part_blue;
      fwd_hit_r  <= fwd_hit_nxt;
      fwd_data_r <= cur_grey;
    end
  end

  // Neighbor values of the current pixel, updated as each pixel retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      upper_left_r <= '0;
    end else if (s1_retire) begin
      left_r       <= cur_grey;
      upper_left_r <= above;
    end
  end

  // Output register.
  logic [MAG_W-1:0] out_mag_r;
  logic [POS_W-1:0] out_row_r, out_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_pos_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mag_r <= mag;
      out_row_r <= POS_W'(s1_pos_r.row - ROW_W'(1));
      out_col_r <= POS_W'(s1_pos_r.col - COL_W'(1));
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.edge_magnitude = out_mag_r;
  assign out_ch.edge_byte      = out_mag_r[PIX_W-1:0];
  assign out_ch.out_row        = out_row_r;
  assign out_ch.out_col        = out_col_r;

endmodule

/* dv/roberts_cross_edge_stream_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// roberts_cross_edge_stream_tb: self-checking bench of the Roberts cross block
// Drives RGB pixel transactions and line width writes, predicts every edge
// result in a scoreboard class and compares each result field by field.
// ============================================================================
module roberts_cross_edge_stream_tb;
  import rce_pkg::*;

  localparam int RANDOM_TARGET  = 1150;  // pixels sent before the wide frame
  localparam int WIDE_PIXELS    = 100;   // pixels of the closing wide frame
  localparam int HOLD_CYCLES    = 300;   // receiver hold-off under pressure
  localparam int DRAIN_CYCLES   = 8;     // lets the last pixels leave the pipeline
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
  localparam int IDLE_PERCENT   = 14;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic [MAG_W-1:0] edge_magnitude;
    logic [PIX_W-1:0] edge_byte;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
  } edge_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the line buffer, the two neighbour
  // registers and the raster counters, and queues the expected edge result
  // of every accepted pixel that produces one.
  // --------------------------------------------------------------------------
  class roberts_checker;
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] left_grey;
    logic [PIX_W-1:0] upper_left_grey;
    logic [ROW_W-1:0] row;
    int unsigned      col;
    logic [CFG_W-1:0] width_reg;
    edge_res_t        expected_edges [$];
    int               errors;
    int               results_seen;

    function new();
      foreach (line_mem[k]) line_mem[k] = '0;
      left_grey       = '0;
      upper_left_grey = '0;
      row             = '0;
      col             = 0;
      width_reg       = CFG_W'(LW_RESET);
      errors          = 0;
      results_seen    = 0;
    endfunction

    function void set_width(logic [CFG_W-1:0] w);
      width_reg = w;
    endfunction

    function int unsigned effective_width();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned luma(pixel_t p);
      return (int'(p.red) * 299) / 1000 + (int'(p.green) * 587) / 1000 +
             (int'(p.blue) * 114) / 1000;
    endfunction

    function int unsigned gap(int unsigned a, int unsigned b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function int pending();
      return expected_edges.size();
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned w;
      int unsigned cur;
      int unsigned above;
      int unsigned mag;
      edge_res_t   e;
      w = effective_width();
      if (p.frame_start) begin
        row = '0;
        col = 0;
      end
      // A width that shrank under the current column closes the row
      // without advancing the row counter.
      if (col >= w) col = 0;
      cur   = luma(p);
      above = line_mem[col];
      if (row >= 2 && col >= 2) begin
        mag              = gap(upper_left_grey, cur) + gap(left_grey, above);
        e.edge_magnitude = MAG_W'(mag);
        e.edge_byte      = PIX_W'(mag);
        e.out_row        = POS_W'(row - ROW_W'(1));
        e.out_col        = POS_W'(col - 1);
        expected_edges.push_back(e);
      end
      upper_left_grey = PIX_W'(above);
      line_mem[col]   = PIX_W'(cur);
      left_grey       = PIX_W'(cur);
      col++;
      if (col >= w) begin
        col = 0;
        row = row + ROW_W'(1);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end else if (errors == 41) begin
        $display("[%0t] further mismatches are counted only", $realtime);
      end
    endtask

    task check_result(edge_res_t got);
      edge_res_t want;
      results_seen++;
      if (expected_edges.size() == 0) begin
        report_mismatch($sformatf("unexpected result mag=%0d row=%0d col=%0d",
                                  got.edge_magnitude, got.out_row, got.out_col));
      end else begin
        want = expected_edges.pop_front();
        if (got.edge_magnitude !== want.edge_magnitude)
          report_mismatch($sformatf("edge_magnitude %0d, expected %0d at (%0d,%0d)",
                                    got.edge_magnitude, want.edge_magnitude,
                                    want.out_row, want.out_col));
        if (got.edge_byte !== want.edge_byte)
          report_mismatch($sformatf("edge_byte %0d, expected %0d at (%0d,%0d)",
                                    got.edge_byte, want.edge_byte,
                                    want.out_row, want.out_col));
        if (got.out_row !== want.out_row)
          report_mismatch($sformatf("out_row %0d, expected %0d",
                                    got.out_row, want.out_row));
        if (got.out_col !== want.out_col)
          report_mismatch($sformatf("out_col %0d, expected %0d",
                                    got.out_col, want.out_col));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  rce_pix_if  pix_bus ();
  rce_edge_if res_bus ();
  rce_cfg_if  cfg_bus ();

  roberts_cross_edge_stream u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_bus.sink),
    .out_ch (res_bus.source),
    .cfg_ch (cfg_bus.sink)
  );

  roberts_checker chk = new();

  // idle_free and stall_req are shared by the stimulus and the receiver. idle_free
  // turns off random gaps on both sides; stall_req asks the receiver for one long hold-off.
  bit idle_free = 1'b0;
  bit stall_req = 1'b0;
  int pixels_sent = 0;
  int width_writes = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All block inputs change with nonblocking assignments right
  // after a rising edge; handshakes are sampled at the edge itself.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input pixel_t p);
    while (!idle_free && $urandom_range(0, 99) < IDLE_PERCENT) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.red         <= p.red;
    pix_bus.green       <= p.green;
    pix_bus.blue        <= p.blue;
    pix_bus.frame_start <= p.frame_start;
    do @(posedge clk); while (!pix_bus.ready);
    chk.note_pixel(p);
    pixels_sent++;
  endtask

  function automatic pixel_t mk_pixel(int r, int g, int b, bit fs);
    pixel_t p;
    p.red         = PIX_W'(r);
    p.green       = PIX_W'(g);
    p.blue        = PIX_W'(b);
    p.frame_start = fs;
    return p;
  endfunction

  // Channels are sometimes pinned to black or full scale so that large and
  // zero gradients, and magnitudes above one byte, show up often.
  function automatic logic [PIX_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return PIX_W'($urandom);
      end
    endcase
  endfunction

  // Sends count pixels. The first one opens a frame when first_start is set;
  // noisy adds stray frame starts. At index stall_at the receiver is asked
  // to hold off while this stream keeps offering pixels.
  task automatic run_pixels(input int count, input bit first_start, input bit noisy,
                            input int stall_at);
    pixel_t p;
    for (int k = 0; k < count; k++) begin
      p.red         = rand_channel();
      p.green       = rand_channel();
      p.blue        = rand_channel();
      p.frame_start = (k == 0) ? first_start : (noisy && $urandom_range(0, 63) == 0);
      if (k == stall_at) stall_req = 1'b1;
      send_pixel(p);
    end
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.line_width <= w;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    chk.set_width(w);
    width_writes++;
  endtask

  // Waits until every predicted result has come back, then gives the last
  // pixels, which may produce nothing, time to leave the pipeline.
  task automatic settle();
    pix_bus.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks every accepted result transaction and drives ready with
  // random gaps, plus one long hold-off counted here when requested.
  // --------------------------------------------------------------------------
  initial begin : receiver
    edge_res_t got;
    int        hold_left;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        got.edge_magnitude = res_bus.edge_magnitude;
        got.edge_byte      = res_bus.edge_byte;
        got.out_row        = res_bus.out_row;
        got.out_col        = res_bus.out_col;
        chk.check_result(got);
      end
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        res_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= idle_free || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: ends the run with a failure when transactions of every kind have
  // stopped, which covers a hung pipeline and lost results.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (pix_bus.valid && pix_bus.ready) ||
          (res_bus.valid && res_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] watchdog: no transaction for %0d cycles, %0d results outstanding",
             $realtime, WATCHDOG_LIMIT, chk.pending());
    $display("roberts_cross_edge_stream_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          phase;
    int unsigned eff;
    int unsigned cfg_val;
    int          count;

    rst_n               <= 1'b0;
    pix_bus.valid       <= 1'b0;
    pix_bus.red         <= '0;
    pix_bus.green       <= '0;
    pix_bus.blue        <= '0;
    pix_bus.frame_start <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.line_width  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame of width 3. Row 0 has the pure primaries; the white and
    // black blocks in rows 1 and 2 give the largest magnitude at (1,1), a
    // one-sided gradient at (2,1) and a flat zero at (3,1).
    write_width(CFG_W'(3));
    send_pixel(mk_pixel(255, 0, 0, 1'b1));
    send_pixel(mk_pixel(0, 255, 0, 1'b0));
    send_pixel(mk_pixel(0, 0, 255, 1'b0));
    send_pixel(mk_pixel(255, 128, 7, 1'b0));
    send_pixel(mk_pixel(255, 255, 255, 1'b0));
    send_pixel(mk_pixel(0, 0, 0, 1'b0));
    send_pixel(mk_pixel(0, 0, 0, 1'b0));
    send_pixel(mk_pixel(255, 255, 255, 1'b0));
    send_pixel(mk_pixel(0, 0, 0, 1'b0));
    repeat (6) send_pixel(mk_pixel(0, 0, 0, 1'b0));
    settle();

    // Widths below the minimum clamp to two columns: never any result.
    write_width(CFG_W'(1));
    send_pixel(mk_pixel(255, 255, 255, 1'b1));
    repeat (3) send_pixel(mk_pixel(17, 200, 99, 1'b0));
    settle();
    write_width(CFG_W'(0));
    send_pixel(mk_pixel(0, 0, 0, 1'b1));
    repeat (3) send_pixel(mk_pixel(255, 0, 255, 1'b0));
    settle();

    // Random frames, mostly narrow. Each opens with a frame start after the
    // width write; some are then narrowed in the middle of a line without a
    // new frame, which ends the row early when the column is past the width.
    // The second frame runs without any idling on either side.
    phase = 0;
    while (pixels_sent < RANDOM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          cfg_val = $urandom_range(0, 1);
        end
        1, 2, 3: begin
          cfg_val = $urandom_range(17, 40);
        end
        default: begin
          cfg_val = $urandom_range(2, 16);
        end
      endcase
      if (phase == 1) cfg_val = 24;
      if (phase == 2) cfg_val = 16;
      idle_free = (phase == 1) || ($urandom_range(0, 4) == 0);
      write_width(CFG_W'(cfg_val));
      eff   = chk.effective_width();
      count = eff * $urandom_range(3, 7) + $urandom_range(0, eff - 1);
      if (count > RANDOM_TARGET - pixels_sent) count = RANDOM_TARGET - pixels_sent;
      // The third frame carries the receiver hold-off, placed once results
      // are flowing so that the pipeline fills and stalls the pixel input.
      run_pixels(count, 1'b1, 1'b1, (phase == 2) ? int'(2 * eff + 3) : -1);
      settle();
      if (eff > 2 && pixels_sent < RANDOM_TARGET && $urandom_range(0, 2) == 0) begin
        write_width(CFG_W'($urandom_range(2, eff - 1)));
        eff   = chk.effective_width();
        count = $urandom_range(eff, 4 * eff);
        if (count > RANDOM_TARGET - pixels_sent) count = RANDOM_TARGET - pixels_sent;
        run_pixels(count, 1'b0, 1'b0, -1);
        settle();
      end
      phase++;
    end

    // All-ones width clamps to the full line buffer; the short run stays in
    // row 0 and must stay silent.
    idle_free = 1'b0;
    write_width(CFG_W'(2047));
    run_pixels(WIDE_PIXELS, 1'b1, 1'b0, -1);
    settle();

    $display("Run covered %0d pixel transactions, %0d edge results and %0d width writes,",
             pixels_sent, chk.results_seen, width_writes);
    $display("including clamped widths, mid-line narrowing, a long stall and an idle-free frame.");
    if (chk.errors == 0) begin
      $display("roberts_cross_edge_stream_tb: PASS");
    end else begin
      $display("%0d mismatches found", chk.errors);
      $display("roberts_cross_edge_stream_tb: FAIL");
    end
    $finish;
  end

endmodule
